>>> hdl/linear_diophantine_solver_top_defines.svh
// ----------------------------------------------------------------------------
// Linear Diophantine solver assertion macros
// Shared concurrent assertion forms for the solver modules.
// ----------------------------------------------------------------------------
`ifndef LINEAR_DIOPHANTINE_SOLVER_TOP_DEFINES_SVH
`define LINEAR_DIOPHANTINE_SOLVER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LDS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ldsolve_pkg.sv
// ----------------------------------------------------------------------------
// Linear Diophantine solver package
// Field widths, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldsolve_pkg;

  // Default operand width and fixed field widths of the stream payload
  localparam int unsigned DEF_WIDTH = 32;
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned SOL_W     = 64;
  localparam int unsigned S_DATA_W  = 3 * FIELD_W;
  localparam int unsigned M_DATA_W  = 2 * SOL_W;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_EU_DIV,
    OP_EU_MUL,
    OP_EU_UPD,
    OP_C_DIV,
    OP_SCALE,
    OP_FIX
  } dp_op_e;

  // Controller to datapath
  typedef struct packed {
    logic   load;
    dp_op_e op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic r1_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/ldsolve_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle, results held until restart.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldsolve_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WIDTH:0]   part;
  logic [WIDTH:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and trial subtract
  always_comb begin
    part  = {rem_q, quo_q[WIDTH-1]};
    diff  = part - {1'b0, dvs_q};
    fits  = ~diff[WIDTH];
    rem_d = fits ? diff[WIDTH-1:0] : part[WIDTH-1:0];
    quo_d = {quo_q[WIDTH-2:0], fits};
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> hdl/ldsolve_dp.sv
// ----------------------------------------------------------------------------
// Linear Diophantine solver datapath
// Operand capture, Euclid remainders and Bezout pair, scaling and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldsolve_dp import ldsolve_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [S_DATA_W-1:0] s_data_i,
  output logic [M_DATA_W-1:0] m_data_o,
  output logic                m_user_o,
  output logic                m_valid_o,
  input  logic                m_ready_i
);

  localparam int unsigned CW = WIDTH + 1;
  localparam int unsigned PW = 2 * CW;

  // Operand fields, low WIDTH bits of each
  logic [WIDTH-1:0] ua, ub, uc;
  logic [WIDTH-1:0] ma_in, mb_in, mc_in;
  logic             a_gt_b;

  logic             a_neg_q, b_neg_q, c_neg_q;
  logic             a_zero_q, b_zero_q, c_zero_q;
  logic             swap_q;
  logic [WIDTH-1:0] c_mag_q;
  logic [WIDTH-1:0] r0_q, r1_q;
  logic signed [CW-1:0] s0_q, s1_q, t0_q, t1_q;
  logic signed [CW-1:0] ps_q, pt_q;
  logic signed [PW-1:0] px_q, py_q;

  logic             div_start;
  logic [WIDTH-1:0] div_num, div_den, quot, rem;
  logic             div_done;

  logic signed [CW-1:0]    k_s, q_s, tval, x_coef, y_coef;
  logic signed [PW-1:0]    ks_full, kt_full, px_full, py_full;
  logic signed [SOL_W-1:0] xs, ys, x_val, y_val, x_out, y_out;
  logic                    special, ok;

  logic [M_DATA_W-1:0] m_data_q;
  logic                m_user_q;
  logic                m_valid_q;

  // Magnitudes and ordering of the incoming request
  always_comb begin
    ua     = s_data_i[0 +: WIDTH];
    ub     = s_data_i[FIELD_W +: WIDTH];
    uc     = s_data_i[2*FIELD_W +: WIDTH];
    ma_in  = ua[WIDTH-1] ? (~ua + WIDTH'(1)) : ua;
    mb_in  = ub[WIDTH-1] ? (~ub + WIDTH'(1)) : ub;
    mc_in  = uc[WIDTH-1] ? (~uc + WIDTH'(1)) : uc;
    a_gt_b = $signed(ua) > $signed(ub);
  end

  // Shared divider: Euclid quotients, then C over the divisor
  assign div_start = (cmd_i.op == OP_EU_DIV) || (cmd_i.op == OP_C_DIV);
  assign div_num   = (cmd_i.op == OP_C_DIV) ? c_mag_q : r0_q;
  assign div_den   = (cmd_i.op == OP_C_DIV) ? r0_q : r1_q;

  ldsolve_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  // Bezout update products and final scaling products
  always_comb begin
    k_s     = signed'({1'b0, quot});
    ks_full = k_s * s1_q;
    kt_full = k_s * t1_q;
    special = a_zero_q | b_zero_q;
    q_s     = signed'({1'b0, quot});
    tval    = c_neg_q ? -q_s : q_s;
    x_coef  = special ? CW'(1) : (swap_q ? t0_q : s0_q);
    y_coef  = special ? CW'(1) : (swap_q ? s0_q : t0_q);
    px_full = tval * x_coef;
    py_full = tval * y_coef;
  end

  // Sign restore and result selection
  always_comb begin
    xs    = SOL_W'(px_q);
    ys    = SOL_W'(py_q);
    x_val = a_neg_q ? -xs : xs;
    y_val = b_neg_q ? -ys : ys;
    ok    = (a_zero_q & b_zero_q) ? c_zero_q : (rem == '0);
    x_out = !ok ? '0 : (a_zero_q ? SOL_W'(1) : x_val);
    y_out = !ok ? '0 : (b_zero_q ? SOL_W'(1) : y_val);
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_neg_q  <= ua[WIDTH-1];
      b_neg_q  <= ub[WIDTH-1];
      c_neg_q  <= uc[WIDTH-1];
      a_zero_q <= (ua == '0);
      b_zero_q <= (ub == '0);
      c_zero_q <= (uc == '0);
      swap_q   <= ~a_gt_b;
      c_mag_q  <= mc_in;
      if ((ua == '0) || (ub == '0)) begin
        r0_q <= ma_in | mb_in;
      end else begin
        r0_q <= a_gt_b ? ma_in : mb_in;
      end
      r1_q <= a_gt_b ? mb_in : ma_in;
      s0_q <= CW'(1);
      s1_q <= '0;
      t0_q <= '0;
      t1_q <= CW'(1);
    end else begin
      unique case (cmd_i.op)
        OP_EU_MUL: begin
          ps_q <= ks_full[CW-1:0];
          pt_q <= kt_full[CW-1:0];
        end
        OP_EU_UPD: begin
          r0_q <= r1_q;
          r1_q <= rem;
          s0_q <= s1_q;
          s1_q <= s0_q - ps_q;
          t0_q <= t1_q;
          t1_q <= t0_q - pt_q;
        end
        OP_SCALE: begin
          px_q <= px_full;
          py_q <= py_full;
        end
        OP_IDLE, OP_EU_DIV, OP_C_DIV, OP_FIX: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FIX) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIX) begin
      m_data_q <= {y_out, x_out};
      m_user_q <= ok;
    end
  end

  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;
  assign m_valid_o = m_valid_q;

  assign stat_o.a_zero   = a_zero_q;
  assign stat_o.b_zero   = b_zero_q;
  assign stat_o.r1_zero  = (r1_q == '0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = ~m_valid_q | m_ready_i;

endmodule

>>> hdl/ldsolve_ctrl.sv
// ----------------------------------------------------------------------------
// Linear Diophantine solver controller
// Sequences capture, Euclid steps, final division, scaling and hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "linear_diophantine_solver_top_defines.svh"

module ldsolve_ctrl import ldsolve_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_EU_TEST,
    S_EU_WAIT,
    S_EU_MUL,
    S_EU_UPD,
    S_C_WAIT,
    S_SCALE,
    S_FIX,
    S_EMIT
  } state_e;

  state_e state_q;
  dp_op_e op_q;
  logic   ready_q;

  // State, operation and ready registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_IDLE;
      ready_q <= 1'b1;
    end else begin
      op_q <= OP_IDLE;
      unique case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            ready_q <= 1'b0;
            state_q <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          priority if (stat_i.a_zero && stat_i.b_zero) begin
            state_q <= S_FIX;
          end else if (stat_i.a_zero || stat_i.b_zero) begin
            op_q    <= OP_C_DIV;
            state_q <= S_C_WAIT;
          end else begin
            state_q <= S_EU_TEST;
          end
        end
        S_EU_TEST: begin
          if (stat_i.r1_zero) begin
            op_q    <= OP_C_DIV;
            state_q <= S_C_WAIT;
          end else begin
            op_q    <= OP_EU_DIV;
            state_q <= S_EU_WAIT;
          end
        end
        S_EU_WAIT: begin
          if (stat_i.div_done) begin
            op_q    <= OP_EU_MUL;
            state_q <= S_EU_MUL;
          end
        end
        S_EU_MUL: begin
          op_q    <= OP_EU_UPD;
          state_q <= S_EU_UPD;
        end
        S_EU_UPD: begin
          state_q <= S_EU_TEST;
        end
        S_C_WAIT: begin
          if (stat_i.div_done) begin
            op_q    <= OP_SCALE;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_q <= S_FIX;
        end
        S_FIX: begin
          if (stat_i.out_free) begin
            op_q    <= OP_FIX;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          ready_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_ready_o  = ready_q;
  assign cmd_o.load = ready_q & s_valid_i;
  assign cmd_o.op   = op_q;

  // Ready only while waiting for a request
  `LDS_ASSERT_SAME(a_ready_idle, clk_i, rst_ni, ready_q, state_q == S_IDLE,
    "ready raised outside idle")
  // A captured request always goes to classification next
  `LDS_ASSERT_NEXT(a_load_classify, clk_i, rst_ni, cmd_o.load, state_q == S_CLASSIFY,
    "capture not followed by classification")
  // The divider only finishes while a division is awaited
  `LDS_ASSERT_SAME(a_div_expected, clk_i, rst_ni, stat_i.div_done,
    (state_q == S_EU_WAIT) || (state_q == S_C_WAIT), "unexpected divider completion")
  // A result is written only into a free output register
  `LDS_ASSERT_SAME(a_fix_free, clk_i, rst_ni, op_q == OP_FIX, stat_i.out_free,
    "result written over a pending one")

endmodule

>>> hdl/linear_diophantine_solver_top.sv
// ----------------------------------------------------------------------------
// Linear Diophantine solver, top level
// Finds integers x, y with A*x + B*y = C by extended Euclid, or flags none.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: A, B and C packed in tdata, each
//   read in its low WIDTH bits as a signed value. Results leave on m_axis:
//   x and y as 64-bit signed values in tdata, the solution flag in tuser
//   (x and y read zero when no solution exists).
//   One request is in flight at a time. Each Euclid step and the final
//   division run through the serial divider, one quotient bit per cycle.
//   s_axis_tready_o rises again in the same cycle as the result turns
//   valid. A single zero coefficient skips the Euclid loop and takes one
//   division only; both zero skip the divisions altogether.
//   A finished result sits in the output register while the next request
//   is accepted; a stalled receiver only holds back the following result.
//   Reset clears the controller and the output valid; s_axis_tready_o is
//   high after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_diophantine_solver_top import ldsolve_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // coef_a [31:0], coef_b [63:32], target_c [95:64]
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // sol_x [63:0], sol_y [127:64]
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  // exists [0]
  output logic                m_axis_tuser_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ldsolve_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ldsolve_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .s_data_i  (s_axis_tdata_i),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i)
  );

endmodule

>>> tb/sv/linear_diophantine_solver_top_test.sv
// ----------------------------------------------------------------------------
// Linear Diophantine solver testbench
// Drives A, B, C requests over the s_axis stream and checks each x, y and
// solution flag on m_axis against a built-in extended Euclid predictor, with
// bursty requests, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_diophantine_solver_top_test;
  import ldsolve_pkg::*;

  localparam int unsigned DUT_WIDTH   = DEF_WIDTH;
  localparam int          HOLD_CYCLES = 5000;
  localparam int          MAX_REPORTS = 10;
  localparam int          RAND_ITEMS  = 270;

  localparam logic signed [FIELD_W-1:0] MAX_POS = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] MIN_NEG = 32'sh8000_0000;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SHUT,
    RX_JITTER
  } rx_mode_e;

  // One predicted answer, with the request kept for reporting
  typedef struct {
    logic signed [FIELD_W-1:0] a;
    logic signed [FIELD_W-1:0] b;
    logic signed [FIELD_W-1:0] c;
    logic signed [SOL_W-1:0]   x;
    logic signed [SOL_W-1:0]   y;
    logic                      exists;
  } solution_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  logic      rx_hold;
  logic      hold_req;
  solution_t solution_q[$];
  int        error_count = 0;
  int        burst_left  = 0;

  linear_diophantine_solver_top #(
    .WIDTH(DUT_WIDTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Read a field in its low DUT_WIDTH bits, sign-extended
  function automatic longint widen(input logic [FIELD_W-1:0] raw);
    longint v;
    v = longint'(raw[DUT_WIDTH-1:0]);
    if (raw[DUT_WIDTH-1]) begin
      v = v - (longint'(1) <<< DUT_WIDTH);
    end
    return v;
  endfunction

  // Extended Euclid on magnitudes; p*cp + q*cq = gcd, coefficients wrap at 64
  function automatic bit [63:0] bezout(input bit [63:0] p, input bit [63:0] q,
                                       output bit [63:0] cp, output bit [63:0] cq);
    bit [63:0] r0, r1, s0, s1, t0, t1, k, nr, ns, nt;
    r0 = p;  r1 = q;
    s0 = 1;  s1 = 0;
    t0 = 0;  t1 = 1;
    while (r1 != 0) begin
      k  = r0 / r1;
      nr = r0 % r1;
      ns = s0 - k * s1;
      nt = t0 - k * t1;
      r0 = r1;  r1 = nr;
      s0 = s1;  s1 = ns;
      t0 = t1;  t1 = nt;
    end
    cp = s0;
    cq = t0;
    return r0;
  endfunction

  function automatic solution_t solve_diophantine(input logic signed [FIELD_W-1:0] a_in,
                                                  input logic signed [FIELD_W-1:0] b_in,
                                                  input logic signed [FIELD_W-1:0] c_in);
    solution_t res;
    longint    a, b, c;
    bit [63:0] ma, mb, g, ca, cb, t, x, y;
    a = widen(a_in);
    b = widen(b_in);
    c = widen(c_in);
    res.a = a_in;  res.b = b_in;  res.c = c_in;
    res.x = '0;    res.y = '0;    res.exists = 1'b0;
    if (a == 0 && b != 0) begin
      // only y carries the answer
      if (c % b == 0) begin
        res.x = 1;  res.y = c / b;  res.exists = 1'b1;
      end
    end else if (b == 0 && a != 0) begin
      if (c % a == 0) begin
        res.x = c / a;  res.y = 1;  res.exists = 1'b1;
      end
    end else if (a == 0 && b == 0) begin
      if (c == 0) begin
        res.x = 1;  res.y = 1;  res.exists = 1'b1;
      end
    end else begin
      // the larger signed operand goes first into Euclid
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      if (a > b) begin
        g = bezout(ma, mb, ca, cb);
      end else begin
        g = bezout(mb, ma, cb, ca);
      end
      if (c % longint'(g) == 0) begin
        t = c / longint'(g);
        x = t * ca;
        y = t * cb;
        if (a < 0) x = -x;
        if (b < 0) y = -y;
        res.x = x;  res.y = y;  res.exists = 1'b1;
      end
    end
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------

  // Offer one request, hold until accepted, then maybe drop valid for a gap
  task automatic send_request(input logic signed [FIELD_W-1:0] a,
                              input logic signed [FIELD_W-1:0] b,
                              input logic signed [FIELD_W-1:0] c);
    int gap;
    s_axis_tdata_i  <= {c, b, a};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    solution_q.push_back(solve_diophantine(a, b, c));
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1200) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait until every answer is back
  task automatic close_phase();
    s_axis_tvalid_i <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_field();
    logic signed [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = int'($urandom_range(0, 128)) - 64;
      7: begin
        case ($urandom_range(0, 3))
          0:       v = MAX_POS;
          1:       v = MIN_NEG;
          2:       v = MIN_NEG + 1;
          default: v = -1;
        endcase
      end
      8:       v = '0;
      default: begin
        v = 32'sd1 <<< $urandom_range(0, 30);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // Receiver stall pattern, overridden by the hold-off
  initial begin : rx_pattern
    int       run_left;
    rx_mode_e mode;
    run_left = 0;
    mode     = RX_OPEN;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 2));
        run_left = $urandom_range(1, 300);
      end
      run_left--;
      case (mode)
        RX_OPEN:  m_axis_tready_i <= !rx_hold;
        RX_SHUT:  m_axis_tready_i <= 1'b0;
        default:  m_axis_tready_i <= !rx_hold && ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Long receiver hold-off on a request pulse, counted here in cycles
  initial begin
    rx_hold <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    solution_t               exp_s;
    logic signed [SOL_W-1:0] got_x, got_y;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_x = m_axis_tdata_o[SOL_W-1:0];
      got_y = m_axis_tdata_o[2*SOL_W-1:SOL_W];
      if (solution_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected result: x=%0d y=%0d exists=%0b", got_x, got_y, m_axis_tuser_o);
        end
      end else begin
        exp_s = solution_q.pop_front();
        if (got_x !== exp_s.x || got_y !== exp_s.y || m_axis_tuser_o !== exp_s.exists) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch for A=%0d B=%0d C=%0d", exp_s.a, exp_s.b, exp_s.c);
            $display("  expected x=%0d y=%0d exists=%0b", exp_s.x, exp_s.y, exp_s.exists);
            $display("  actual   x=%0d y=%0d exists=%0b", got_x, got_y, m_axis_tuser_o);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // One or both coefficients zero
  task automatic test_zero_coefficients();
    send_request(0, 0, 0);
    send_request(0, 0, 5);
    send_request(0, 7, 21);
    send_request(0, -7, 22);
    send_request(-6, 0, -18);
    send_request(4, 0, MIN_NEG);
    send_request(MIN_NEG, 0, MIN_NEG);
    send_request(0, -1, MIN_NEG);
    close_phase();
  endtask

  // Field extremes and the longest Euclid chain
  task automatic test_extreme_operands();
    send_request(MIN_NEG, MIN_NEG, MIN_NEG);
    send_request(MAX_POS, MAX_POS - 1, MAX_POS);
    send_request(MIN_NEG, MAX_POS, MAX_POS);
    send_request(MIN_NEG + 1, MIN_NEG, -1);
    send_request(32'sd1836311903, 32'sd1134903170, MIN_NEG);
    send_request(-32'sd1134903170, 32'sd1836311903, MAX_POS);
    close_phase();
  endtask

  // Sign restoration, operand order and missing solutions
  task automatic test_signs_and_order();
    send_request(12, 18, 7);
    send_request(12, -18, -30);
    send_request(-12, 18, 30);
    send_request(-12, -18, MAX_POS - 1);
    send_request(1, 1, -1);
    send_request(-1, -1, MAX_POS);
    send_request(5, 5, 10);
    send_request(3, 5, 1);
    send_request(5, 3, 1);
    send_request(-5, 3, 1);
    close_phase();
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_receiver_holdoff();
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (8) begin
      send_request(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                   $urandom);
    end
    close_phase();
  endtask

  task automatic test_random_systems();
    logic signed [FIELD_W-1:0] a, b, c, tmp;
    longint                    fa, fb, fn;
    int                        f;
    repeat (RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          a = pick_field();
          b = pick_field();
          c = pick_field();
        end
        6, 7: begin
          // shared factor, so C is often a multiple of the gcd
          f = $urandom_range(2, 5000);
          a = f * (int'($urandom_range(0, 4000)) - 2000);
          b = f * (int'($urandom_range(0, 4000)) - 2000);
          c = ($urandom_range(0, 3) == 0) ? $urandom
                                          : f * (int'($urandom_range(0, 800000)) - 400000);
        end
        8: begin
          // neighbouring Fibonacci numbers give long Euclid chains
          fa = 1;
          fb = 1;
          repeat ($urandom_range(20, 44)) begin
            fn = fa + fb;
            fa = fb;
            fb = fn;
          end
          a = FIELD_W'(fb);
          b = FIELD_W'(fa);
          if ($urandom_range(0, 1)) a = -a;
          if ($urandom_range(0, 1)) b = -b;
          if ($urandom_range(0, 1)) begin
            tmp = a;  a = b;  b = tmp;
          end
          c = $urandom;
        end
        default: begin
          a = $urandom;
          b = $urandom;
          c = $urandom;
        end
      endcase
      send_request(a, b, c);
    end
    close_phase();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_ni          <= 1'b0;
    hold_req        <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_coefficients();
    test_extreme_operands();
    test_signs_and_order();
    test_receiver_holdoff();
    test_random_systems();

    // let any stray result show up
    repeat (2000) @(posedge clk_i);
    if (error_count == 0 && solution_q.size() == 0) begin
      $display("[linear_diophantine_solver_top] OK");
    end else begin
      $display("[linear_diophantine_solver_top] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("[linear_diophantine_solver_top] ERROR");
    $finish;
  end

endmodule

>>> linear_diophantine_solver_top.f
+incdir+hdl
hdl/ldsolve_pkg.sv
hdl/ldsolve_div.sv
hdl/ldsolve_dp.sv
hdl/ldsolve_ctrl.sv
hdl/linear_diophantine_solver_top.sv
tb/sv/linear_diophantine_solver_top_test.sv
